>>> hdl/ytc_pkg.sv
// Package for the text-packet to CAN-frame parser.
// Holds the word types of both channels, the fixed limits and the hex helper.
// No dependencies.
package ytc_pkg;

   localparam int MAX_WORDS        = 64;
   localparam int MAX_WORD_CHARS   = 16;
   localparam int MAX_PACKET_CHARS = 512;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X_LO  = 8'h78;
   localparam logic [7:0] CHAR_X_UP  = 8'h58;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0d;

   localparam logic [2:0] PH_LEAD   = 3'd0;
   localparam logic [2:0] PH_ZERO   = 3'd1;
   localparam logic [2:0] PH_PREFIX = 3'd2;
   localparam logic [2:0] PH_DIGITS = 3'd3;
   localparam logic [2:0] PH_STOP   = 3'd4;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_packet;
   } ytc_req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [5:0]  byte_index;
      logic [7:0]  source;
      logic [17:0] pgn;
      logic [2:0]  priority_res;
      logic [6:0]  byte_count;
      logic        valid_res;
      logic        last;
   } ytc_rsp_type;

   // Returns a flag in the top bit that is set for a hex digit, and the digit value below it.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'b0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

>>> hdl/yd_raw_text_to_can_frame_unit.sv
// Top level of the text-packet to CAN-frame parser, built on the types and limits of ytc_pkg.
// A result word is written into the registered result queue when the character word that causes it is accepted.
// Throughput: one character word per cycle; the final word of a packet makes up to two
// result words, which a four-entry result queue absorbs, so input stalls only while the
// queue holds three or more words.
// Reset clears the parser state and empties the result queue.
module yd_raw_text_to_can_frame_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ytc_pkg::ytc_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ytc_pkg::ytc_rsp_type rsp_word
);
   import ytc_pkg::*;

   logic [6:0]  word_count_ff, word_count_in;
   logic        inside_word_ff, inside_word_in;
   logic [3:0]  chars_in_word_ff, chars_in_word_in;
   logic [31:0] hex_acc_ff, hex_acc_in;
   logic [2:0]  hex_phase_ff, hex_phase_in;
   logic [31:0] header_id_ff, header_id_in;
   logic [9:0]  packet_chars_ff, packet_chars_in;
   logic        text_ended_ff, text_ended_in;

   ytc_rsp_type q_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   logic        req_accept, rsp_pop;
   logic        active, finish, emit_data, valid_end;
   logic [7:0]  c;
   logic [4:0]  dig;
   logic [31:0] shifted;
   logic [5:0]  data_index;
   logic [1:0]  n_push;
   ytc_rsp_type data_res, end_res, slot0, slot1;

   assign req_accept = req_valid && !req_stall;
   assign rsp_pop    = rsp_valid && !rsp_stall;
   assign req_stall  = count_ff > QCNT_W'(QDEPTH - 2);
   assign rsp_valid  = count_ff != '0;
   assign rsp_word   = q_ff[rd_ptr_ff];

   assign c       = req_word.char_in;
   assign dig     = hex_digit(c);
   assign active  = !text_ended_ff && packet_chars_ff < 10'(MAX_PACKET_CHARS);

   always_comb begin
      word_count_in    = word_count_ff;
      inside_word_in   = inside_word_ff;
      chars_in_word_in = chars_in_word_ff;
      hex_acc_in       = hex_acc_ff;
      hex_phase_in     = hex_phase_ff;
      header_id_in     = header_id_ff;
      packet_chars_in  = packet_chars_ff;
      text_ended_in    = text_ended_ff;
      finish           = 1'b0;
      emit_data        = 1'b0;
      data_index       = '0;
      valid_end        = 1'b0;
      shifted          = '0;
      if (req_accept) begin
         if (active) begin
            packet_chars_in = packet_chars_ff + 10'd1;
            if (c == CHAR_NUL || c == CHAR_SPACE) begin
               finish = 1'b1;
               if (c == CHAR_NUL) begin
                  text_ended_in = 1'b1;
               end
            end else begin
               if (!inside_word_ff && word_count_ff < 7'(MAX_WORDS)) begin
                  word_count_in    = word_count_ff + 7'd1;
                  inside_word_in   = 1'b1;
                  chars_in_word_in = '0;
                  hex_acc_in       = '0;
                  hex_phase_in     = PH_LEAD;
               end
               if (inside_word_in && chars_in_word_in < 4'(MAX_WORD_CHARS - 1)) begin
                  chars_in_word_in = chars_in_word_in + 4'd1;
                  shifted = (hex_acc_in[31:28] != 4'd0) ? 32'hffff_ffff
                                                        : {hex_acc_in[27:0], dig[3:0]};
                  unique case (hex_phase_in)
                     PH_LEAD: begin
                        if (c >= CHAR_TAB && c <= CHAR_CR) begin
                           hex_phase_in = PH_LEAD;
                        end else if (c == CHAR_ZERO) begin
                           hex_acc_in   = '0;
                           hex_phase_in = PH_ZERO;
                        end else if (dig[4]) begin
                           hex_acc_in   = {28'd0, dig[3:0]};
                           hex_phase_in = PH_DIGITS;
                        end else begin
                           hex_acc_in   = '0;
                           hex_phase_in = PH_STOP;
                        end
                     end
                     PH_ZERO: begin
                        if (c == CHAR_X_LO || c == CHAR_X_UP) begin
                           hex_phase_in = PH_PREFIX;
                        end else if (dig[4]) begin
                           hex_acc_in   = {28'd0, dig[3:0]};
                           hex_phase_in = PH_DIGITS;
                        end else begin
                           hex_phase_in = PH_STOP;
                        end
                     end
                     PH_PREFIX: begin
                        if (dig[4]) begin
                           hex_acc_in   = {28'd0, dig[3:0]};
                           hex_phase_in = PH_DIGITS;
                        end else begin
                           hex_acc_in   = '0;
                           hex_phase_in = PH_STOP;
                        end
                     end
                     PH_DIGITS: begin
                        if (dig[4]) begin
                           hex_acc_in = shifted;
                        end else begin
                           hex_phase_in = PH_STOP;
                        end
                     end
                     default: begin
                        hex_phase_in = PH_STOP;
                     end
                  endcase
               end
            end
         end
         if (req_word.end_of_packet) begin
            finish = 1'b1;
         end
         if (finish && inside_word_in) begin
            inside_word_in = 1'b0;
            if (word_count_in == 7'd3) begin
               header_id_in = hex_acc_in;
            end else if (word_count_in >= 7'd4) begin
               emit_data  = 1'b1;
               data_index = 6'(word_count_in - 7'd4);
            end
         end
         valid_end = word_count_in > 7'd2;
      end
   end

   always_comb begin
      data_res            = '0;
      data_res.kind       = KIND_DATA;
      data_res.data_byte  = hex_acc_in[7:0];
      data_res.byte_index = data_index;
      end_res             = '0;
      end_res.kind        = KIND_END;
      end_res.last        = 1'b1;
      end_res.valid_res   = valid_end;
      if (valid_end) begin
         end_res.source       = header_id_in[7:0];
         end_res.pgn          = header_id_in[25:8];
         end_res.priority_res = header_id_in[28:26];
         end_res.byte_count   = word_count_in - 7'd3;
      end
      slot0  = emit_data ? data_res : end_res;
      slot1  = end_res;
      n_push = {1'b0, emit_data} + {1'b0, req_accept && req_word.end_of_packet};
      wr_ptr_in = wr_ptr_ff + QPTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(rsp_pop);
      count_in  = count_ff + QCNT_W'(n_push) - QCNT_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff    <= '0;
         inside_word_ff   <= 1'b0;
         chars_in_word_ff <= '0;
         hex_acc_ff       <= '0;
         hex_phase_ff     <= PH_LEAD;
         header_id_ff     <= '0;
         packet_chars_ff  <= '0;
         text_ended_ff    <= 1'b0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         count_ff         <= '0;
      end else begin
         if (req_accept && req_word.end_of_packet) begin
            word_count_ff    <= '0;
            inside_word_ff   <= 1'b0;
            chars_in_word_ff <= '0;
            hex_acc_ff       <= '0;
            hex_phase_ff     <= PH_LEAD;
            header_id_ff     <= '0;
            packet_chars_ff  <= '0;
            text_ended_ff    <= 1'b0;
         end else begin
            word_count_ff    <= word_count_in;
            inside_word_ff   <= inside_word_in;
            chars_in_word_ff <= chars_in_word_in;
            hex_acc_ff       <= hex_acc_in;
            hex_phase_ff     <= hex_phase_in;
            header_id_ff     <= header_id_in;
            packet_chars_ff  <= packet_chars_in;
            text_ended_ff    <= text_ended_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         q_ff[wr_ptr_ff] <= slot0;
      end
      if (n_push == 2'd2) begin
         q_ff[QPTR_W'(wr_ptr_ff + 1'b1)] <= slot1;
      end
   end

endmodule

>>> test/ytc_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the text-packet to CAN-frame parser testbench: it predicts result words
// from accepted character words and checks the result words in order.
// Depends on ytc_pkg for the word types, the limits and the character constants.
package ytc_tb_pkg;
   import ytc_pkg::*;

   class frame_scoreboard;
      ytc_rsp_type expected_frames[$];
      int unsigned errors;
      logic [6:0]  word_cnt;
      logic        in_word;
      logic [3:0]  word_chars;
      logic [31:0] hex_acc;
      logic [2:0]  phase;
      logic [31:0] can_id;
      logic [9:0]  pkt_chars;
      logic        text_done;

      function new();
         errors = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         word_cnt   = '0;
         in_word    = 1'b0;
         word_chars = '0;
         hex_acc    = '0;
         phase      = PH_LEAD;
         can_id     = '0;
         pkt_chars  = '0;
         text_done  = 1'b0;
      endfunction

      // The third word is the CAN id; every later word yields one data byte.
      function void close_word();
         ytc_rsp_type r;
         logic [6:0]  idx;
         if (!in_word) return;
         in_word = 1'b0;
         if (word_cnt == 7'd0) return;
         idx = word_cnt - 7'd1;
         if (idx == 7'd2) begin
            can_id = hex_acc;
         end else if (idx >= 7'd3) begin
            r = '0;
            r.kind = KIND_DATA;
            r.data_byte = hex_acc[7:0];
            r.byte_index = 6'(idx - 7'd3);
            expected_frames.push_back(r);
         end
      endfunction

      function void note_char(ytc_req_type w);
         logic [7:0]  c;
         logic        is_hex;
         logic [3:0]  dig;
         ytc_rsp_type r;
         c = w.char_in;
         is_hex = 1'b1;
         dig = '0;
         if (c >= 8'h30 && c <= 8'h39) begin
            dig = 4'(c - 8'h30);
         end else if (c >= 8'h61 && c <= 8'h66) begin
            dig = 4'(c - 8'h57);
         end else if (c >= 8'h41 && c <= 8'h46) begin
            dig = 4'(c - 8'h37);
         end else begin
            is_hex = 1'b0;
         end
         if (!text_done && pkt_chars < MAX_PACKET_CHARS) begin
            pkt_chars++;
            if (c == CHAR_NUL) begin
               close_word();
               text_done = 1'b1;
            end else if (c == CHAR_SPACE) begin
               close_word();
            end else begin
               if (!in_word && word_cnt < MAX_WORDS) begin
                  word_cnt++;
                  in_word = 1'b1;
                  word_chars = '0;
                  hex_acc = '0;
                  phase = PH_LEAD;
               end
               if (in_word && word_chars < MAX_WORD_CHARS - 1) begin
                  word_chars++;
                  case (phase)
                     PH_LEAD: begin
                        if (!(c >= CHAR_TAB && c <= CHAR_CR)) begin
                           if (c == CHAR_ZERO) begin
                              hex_acc = '0;
                              phase = PH_ZERO;
                           end else if (is_hex) begin
                              hex_acc = {28'b0, dig};
                              phase = PH_DIGITS;
                           end else begin
                              hex_acc = '0;
                              phase = PH_STOP;
                           end
                        end
                     end
                     PH_ZERO: begin
                        if (c == CHAR_X_LO || c == CHAR_X_UP) begin
                           phase = PH_PREFIX;
                        end else if (is_hex) begin
                           hex_acc = {28'b0, dig};
                           phase = PH_DIGITS;
                        end else begin
                           phase = PH_STOP;
                        end
                     end
                     PH_PREFIX: begin
                        if (is_hex) begin
                           hex_acc = {28'b0, dig};
                           phase = PH_DIGITS;
                        end else begin
                           hex_acc = '0;
                           phase = PH_STOP;
                        end
                     end
                     PH_DIGITS: begin
                        if (!is_hex) begin
                           phase = PH_STOP;
                        end else if (hex_acc > 32'h0fff_ffff) begin
                           hex_acc = '1;
                        end else begin
                           hex_acc = {hex_acc[27:0], dig};
                        end
                     end
                     default: begin
                        phase = PH_STOP;
                     end
                  endcase
               end
            end
         end
         if (w.end_of_packet) begin
            close_word();
            r = '0;
            r.kind = KIND_END;
            r.last = 1'b1;
            if (word_cnt > 7'd2) begin
               r.source = can_id[7:0];
               r.pgn = can_id[25:8];
               r.priority_res = can_id[28:26];
               r.byte_count = word_cnt - 7'd3;
               r.valid_res = 1'b1;
            end
            expected_frames.push_back(r);
            clear_parse();
         end
      endfunction

      function string show(ytc_rsp_type w);
         return $sformatf("kind %0d byte %02h index %0d source %02h pgn %05h prio %0d count %0d valid %0d last %0d",
                          w.kind, w.data_byte, w.byte_index, w.source, w.pgn,
                          w.priority_res, w.byte_count, w.valid_res, w.last);
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= 10) begin
            $display("%s", msg);
         end
      endfunction

      function void check_word(ytc_rsp_type got);
         ytc_rsp_type exp_w;
         if (expected_frames.size() == 0) begin
            note_error({"unexpected result word: ", show(got)});
            return;
         end
         exp_w = expected_frames.pop_front();
         if (got !== exp_w) begin
            note_error({"result mismatch\n  expected: ", show(exp_w), "\n  actual:   ", show(got)});
         end
      endfunction
   endclass

endpackage

>>> test/tb_yd_raw_text_to_can_frame_unit.sv
`timescale 1ns / 100ps
// Testbench top for yd_raw_text_to_can_frame_unit: sends text packets one character word at
// a time with random gaps and result stalls, and checks every result word in order.
// Depends on ytc_pkg, ytc_tb_pkg and the block under test.
module tb_yd_raw_text_to_can_frame_unit;
   import ytc_pkg::*;
   import ytc_tb_pkg::*;

   localparam int HANG_LIMIT   = 3000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_CHARS = 900;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ytc_req_type req_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   ytc_rsp_type rsp_word;

   frame_scoreboard frames = new();
   logic [7:0]      text_q[$];
   int unsigned     sent_chars = 0;
   int unsigned     idle_cycles = 0;
   int unsigned     rsp_seen = 0;
   bit              rsp_holding = 1'b0;
   int              send_mode = 0;

   yd_raw_text_to_can_frame_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned draw_gap(int mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 17);
         default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
      endcase
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   function automatic logic [7:0] hex_char();
      logic [7:0] d;
      d = 8'($urandom_range(0, 15));
      if (d < 8'd10) return 8'h30 + d;
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + d - 8'd10;
   endfunction

   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == CHAR_SPACE);
      return c;
   endfunction

   function automatic void put_word();
      int unsigned start;
      int unsigned ndig;
      start = text_q.size();
      if ($urandom_range(0, 15) == 0) begin
         repeat ($urandom_range(1, 20)) text_q.push_back(junk_char());
         return;
      end
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 2)) text_q.push_back(8'($urandom_range(9, 13)));
      end
      case ($urandom_range(0, 5))
         0: put_text("0x");
         1: put_text("0X");
         2: text_q.push_back(CHAR_ZERO);
         default: ;
      endcase
      ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 18) : $urandom_range(0, 8);
      repeat (ndig) text_q.push_back(hex_char());
      if ($urandom_range(0, 7) == 0) text_q.push_back(junk_char());
      if (text_q.size() == start) text_q.push_back(hex_char());
   endfunction

   function automatic void build_packet(int unsigned nwords);
      text_q.delete();
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) text_q.push_back(CHAR_SPACE);
      end
      for (int w = 0; w < nwords; w++) begin
         if (w > 0) begin
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1)
               text_q.push_back(CHAR_SPACE);
         end
         put_word();
      end
      if ($urandom_range(0, 15) == 0) begin
         text_q.push_back(CHAR_NUL);
         repeat ($urandom_range(0, 4)) text_q.push_back(junk_char());
      end else if ($urandom_range(0, 3) == 0) begin
         text_q.push_back(CHAR_SPACE);
      end
      if (text_q.size() == 0) text_q.push_back(CHAR_SPACE);
   endfunction

   task automatic send_char(input logic [7:0] c, input logic eop);
      int unsigned gap;
      gap = rsp_holding ? 0 : draw_gap(send_mode);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= ytc_req_type'{char_in: c, end_of_packet: eop};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frames.note_char(req_word);
      sent_chars++;
   endtask

   task automatic send_text();
      send_mode = $urandom_range(0, 2);
      foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames.expected_frames.size() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned pkt_num;
      int unsigned nwords;
      pkt_num = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      text_q.delete();
      put_text("1 2  \t0X1cFfFF99 0x +");
      text_q.push_back(CHAR_NUL);
      text_q.push_back(8'hFF);
      send_text();
      text_q.delete();
      put_text("01");
      send_text();
      text_q.delete();
      put_text("0 0 9 123456789abcdef01");
      send_text();
      wait_drained();

      text_q.delete();
      repeat (MAX_WORDS + 6) begin
         text_q.push_back(hex_char());
         text_q.push_back(CHAR_SPACE);
      end
      send_text();
      text_q.delete();
      repeat (40) begin
         repeat (14) text_q.push_back(hex_char());
         text_q.push_back(CHAR_SPACE);
      end
      void'(text_q.pop_back());
      send_text();

      while (sent_chars < RANDOM_CHARS) begin
         pkt_num++;
         nwords = ($urandom_range(0, 9) < 2) ? $urandom_range(0, 2) : $urandom_range(3, 12);
         build_packet(nwords);
         send_text();
         if (pkt_num % 16 == 0) wait_drained();
      end
      req_valid <= 1'b0;

      while (frames.expected_frames.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (frames.errors == 0 && frames.expected_frames.size() == 0) begin
         $display("tb_yd_raw_text_to_can_frame_unit passed");
      end else begin
         $display("tb_yd_raw_text_to_can_frame_unit failed");
      end
      $finish;
   end

   // The result side holds off once for a long stretch so that the block backs up.
   initial begin
      int unsigned gap;
      int          rsp_mode;
      rsp_mode = 1;
      repeat (3) @(posedge clock);
      forever begin
         if (rsp_seen % 40 == 0) rsp_mode = $urandom_range(0, 2);
         gap = draw_gap(rsp_mode);
         if (rsp_seen == 30) begin
            rsp_holding = 1'b1;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_holding = 1'b0;
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         frames.check_word(rsp_word);
         rsp_seen++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == HANG_LIMIT) begin
         $display("tb_yd_raw_text_to_can_frame_unit failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

>>> sim.f
hdl/ytc_pkg.sv
hdl/yd_raw_text_to_can_frame_unit.sv
test/ytc_tb_pkg.sv
test/tb_yd_raw_text_to_can_frame_unit.sv
